// File: hw/rtl/range_add_range_sum_mod_unit_defines.svh
// Assertion macros for the range add / range sum unit
`ifndef RANGE_ADD_RANGE_SUM_MOD_UNIT_DEFINES_SVH
`define RANGE_ADD_RANGE_SUM_MOD_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define RASM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rasm assertion failed");
`define RASM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rasm assertion failed");
`else
`define RASM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RASM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: hw/rtl/rasm_pkg.sv
// Types, constants and helpers shared by the range add / range sum unit
`default_nettype none

package rasm_pkg;

    localparam int DATA_W           = 31;
    localparam int IDX_W            = 11;
    localparam int CFG_IDX_W        = 2;
    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int MM_CNT_W         = $clog2(DATA_W);

    localparam logic [DATA_W-1:0]    MOD_RESET  = 31'h7FFF_FFFF;
    localparam logic [IDX_W-1:0]     ALEN_RESET = 11'd1024;

    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALEN    = 2'd1;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_SUM = 1'b1;

    localparam logic [1:0] PH_ENTER      = 2'd0;
    localparam logic [1:0] PH_LEFT_DONE  = 2'd1;
    localparam logic [1:0] PH_RIGHT_DONE = 2'd2;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_VRED,
        ST_VISIT,
        ST_AP_RD,
        ST_AP_T,
        ST_AP_S,
        ST_AP_P,
        ST_AP_WR,
        ST_PU_RD,
        ST_PU_T,
        ST_PU_WR,
        ST_SUM_RDL,
        ST_SUM_L,
        ST_SUM_RDR,
        ST_SUM_R,
        ST_SUM_WR,
        ST_Q_RD,
        ST_Q_S,
        ST_RESULT
    } t_state;

    typedef enum logic [1:0] {
        AR_POP,
        AR_RIGHT,
        AR_DESCEND
    } t_apret;

    typedef struct packed {
        logic rd_en;
        logic wr_sum;
        logic wr_tag;
    } t_mem_ctl;

    // x, y < m
    function automatic logic [DATA_W-1:0] add_mod(input logic [DATA_W-1:0] x,
                                                  input logic [DATA_W-1:0] y,
                                                  input logic [DATA_W-1:0] m);
        logic [DATA_W:0] s;
        logic [DATA_W:0] d;
        s = {1'b0, x} + {1'b0, y};
        d = s - {1'b0, m};
        add_mod = (s >= {1'b0, m}) ? d[DATA_W-1:0] : s[DATA_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rasm_in_if.sv
// Input word channel
`default_nettype none

interface rasm_in_if;
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic [rasm_pkg::IDX_W-1:0]   range_low;
    logic [rasm_pkg::IDX_W-1:0]   range_high;
    logic [rasm_pkg::DATA_W-1:0]  add_value;

    modport source (output valid, output opcode, output range_low, output range_high,
                    output add_value, input ready);
    modport sink   (input valid, input opcode, input range_low, input range_high,
                    input add_value, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/rasm_out_if.sv
// Result word channel
`default_nettype none

interface rasm_out_if;
    logic                         valid;
    logic                         ready;
    logic [rasm_pkg::DATA_W-1:0]  range_sum;

    modport source (output valid, output range_sum, input ready);
    modport sink   (input valid, input range_sum, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/rasm_cfg_if.sv
// Configuration write channel
`default_nettype none

interface rasm_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [rasm_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [rasm_pkg::DATA_W-1:0]     data;

    modport source (output valid, output reg_index, output data, input ready);
    modport sink   (input valid, input reg_index, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/rasm_mulmod.sv
// Shared bit-serial modular multiplier: (a * b) mod m, b < m, one bit of a per cycle
`default_nettype none

module rasm_mulmod (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [rasm_pkg::DATA_W-1:0] i_a,
    input  wire logic [rasm_pkg::DATA_W-1:0] i_b,
    input  wire logic [rasm_pkg::DATA_W-1:0] i_m,
    output logic                             o_done,
    output logic [rasm_pkg::DATA_W-1:0]      o_res
);

    localparam int W = rasm_pkg::DATA_W;

    logic                         r_busy, n_busy;
    logic                         r_done, n_done;
    logic [rasm_pkg::MM_CNT_W-1:0] r_cnt, n_cnt;
    logic [W-1:0]                 r_a, n_a;
    logic [W-1:0]                 r_b, n_b;
    logic [W-1:0]                 r_m, n_m;
    logic [W-1:0]                 r_r, n_r;

    logic [W:0] dbl;
    logic [W:0] dbl_red;
    logic [W:0] acc;
    logic [W:0] acc_red;

    always_comb begin
        dbl     = {r_r, 1'b0};
        dbl_red = (dbl >= {1'b0, r_m}) ? (dbl - {1'b0, r_m}) : dbl;
        acc     = dbl_red + (r_a[W-1] ? {1'b0, r_b} : '0);
        acc_red = (acc >= {1'b0, r_m}) ? (acc - {1'b0, r_m}) : acc;
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_b    = r_b;
        n_m    = r_m;
        n_r    = r_r;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_a    = i_a;
            n_b    = i_b;
            n_m    = i_m;
            n_r    = '0;
        end else if (r_busy) begin
            n_r   = acc_red[W-1:0];
            n_a   = {r_a[W-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == rasm_pkg::MM_CNT_W'(W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_a <= n_a;
        r_b <= n_b;
        r_m <= n_m;
        r_r <= n_r;
    end

    assign o_done = r_done;
    assign o_res  = r_r;

endmodule

`default_nettype wire

// File: hw/rtl/rasm_mem.sv
// Node sum and lazy tag memories, one address, registered read
`default_nettype none

module rasm_mem #(
    parameter int MAX_ELEMENTS = rasm_pkg::MAX_ELEMENTS_DEF
) (
    input  wire logic                                        i_clk,
    input  wire rasm_pkg::t_mem_ctl                          i_ctl,
    input  wire logic [$clog2(4 * MAX_ELEMENTS)-1:0]         i_addr,
    input  wire logic [rasm_pkg::DATA_W-1:0]                 i_sum,
    input  wire logic [rasm_pkg::DATA_W-1:0]                 i_tag,
    output logic [rasm_pkg::DATA_W-1:0]                      o_sum,
    output logic [rasm_pkg::DATA_W-1:0]                      o_tag
);

    localparam int DEPTH = 4 * MAX_ELEMENTS;

    logic [rasm_pkg::DATA_W-1:0] r_sums [DEPTH];
    logic [rasm_pkg::DATA_W-1:0] r_tags [DEPTH];
    logic [rasm_pkg::DATA_W-1:0] r_rd_sum;
    logic [rasm_pkg::DATA_W-1:0] r_rd_tag;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_sum) begin
            r_sums[i_addr] <= i_sum;
        end
        if (i_ctl.wr_tag) begin
            r_tags[i_addr] <= i_tag;
        end
        if (i_ctl.rd_en) begin
            r_rd_sum <= r_sums[i_addr];
            r_rd_tag <= r_tags[i_addr];
        end
    end

    assign o_sum = r_rd_sum;
    assign o_tag = r_rd_tag;

endmodule

`default_nettype wire

// File: hw/rtl/rasm_ctrl.sv
// Sequencer: config registers, tree walk with explicit stack, result register
`default_nettype none

`include "range_add_range_sum_mod_unit_defines.svh"

module rasm_ctrl #(
    parameter int MAX_ELEMENTS = rasm_pkg::MAX_ELEMENTS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    rasm_in_if.sink                                   i_item,
    rasm_out_if.source                                o_result,
    rasm_cfg_if.sink                                  i_cfg,
    output rasm_pkg::t_mem_ctl                        o_mem_ctl,
    output logic [$clog2(4 * MAX_ELEMENTS)-1:0]       o_mem_addr,
    output logic [rasm_pkg::DATA_W-1:0]               o_mem_sum,
    output logic [rasm_pkg::DATA_W-1:0]               o_mem_tag,
    input  wire logic [rasm_pkg::DATA_W-1:0]          i_mem_sum,
    input  wire logic [rasm_pkg::DATA_W-1:0]          i_mem_tag,
    output logic                                      o_mm_start,
    output logic [rasm_pkg::DATA_W-1:0]               o_mm_a,
    output logic [rasm_pkg::DATA_W-1:0]               o_mm_b,
    output logic [rasm_pkg::DATA_W-1:0]               o_mm_m,
    input  wire logic                                 i_mm_done,
    input  wire logic [rasm_pkg::DATA_W-1:0]          i_mm_res
);

    localparam int W     = rasm_pkg::DATA_W;
    localparam int NODES = 4 * MAX_ELEMENTS;
    localparam int AW    = $clog2(NODES);
    localparam int IW    = $clog2(MAX_ELEMENTS + 1);
    localparam int CW    = (IW > rasm_pkg::IDX_W) ? IW : rasm_pkg::IDX_W;
    localparam int D     = $clog2(MAX_ELEMENTS) + 2;
    localparam int SPW   = $clog2(D + 1);
    localparam int SIW   = $clog2(D);

    rasm_pkg::t_state r_state, n_state;
    rasm_pkg::t_apret r_ap_ret, n_ap_ret;

    logic [W-1:0]                 r_modulus;
    logic [rasm_pkg::IDX_W-1:0]   r_alen;
    logic [W-1:0]                 mz;
    logic [W-1:0]                 one_m;

    logic              r_op, n_op;
    logic [CW-1:0]     r_lo, n_lo;
    logic [CW-1:0]     r_hi, n_hi;
    logic [W-1:0]      r_val, n_val;
    logic [W-1:0]      r_acc, n_acc;
    logic [W-1:0]      r_t, n_t;
    logic [W-1:0]      r_s, n_s;
    logic [W-1:0]      r_p, n_p;
    logic [W-1:0]      r_push, n_push;
    logic              r_issued, n_issued;
    logic [AW-1:0]     r_clr, n_clr;
    logic              r_out_valid, n_out_valid;
    logic [W-1:0]      r_out_sum, n_out_sum;

    logic [AW-1:0]     r_node, n_node;
    logic [IW-1:0]     r_nl, n_nl;
    logic [IW-1:0]     r_nr, n_nr;
    logic [1:0]        r_ph, n_ph;
    logic [SPW-1:0]    r_sp, n_sp;

    logic [AW-1:0]     r_stk_node [D];
    logic [IW-1:0]     r_stk_nl   [D];
    logic [IW-1:0]     r_stk_nr   [D];
    logic [1:0]        r_stk_ph   [D];
    logic [AW-1:0]     n_stk_node [D];
    logic [IW-1:0]     n_stk_nl   [D];
    logic [IW-1:0]     n_stk_nr   [D];
    logic [1:0]        n_stk_ph   [D];

    logic [AW-1:0]     r_ap_node, n_ap_node;
    logic [IW-1:0]     r_ap_len, n_ap_len;
    logic [W-1:0]      r_ap_val, n_ap_val;

    logic [IW:0]       mid_sum;
    logic [IW-1:0]     mid;
    logic [CW-1:0]     nl_c, nr_c;
    logic              out_rng, covered;
    logic [IW-1:0]     node_len;
    logic [AW-1:0]     left, right;
    logic [SPW-1:0]    sp_m1;
    logic [CW-1:0]     lo_c, hi_raw, len_c, al_c, hi_c;
    logic              empty;
    logic              mm_step;
    logic              do_pop, do_desc;

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= rasm_pkg::MOD_RESET;
            r_alen    <= rasm_pkg::ALEN_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.reg_index)
                rasm_pkg::CFG_MODULUS: r_modulus <= i_cfg.data;
                rasm_pkg::CFG_ALEN:    r_alen    <= i_cfg.data[rasm_pkg::IDX_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;
    assign mz          = (r_modulus == '0) ? W'(1) : r_modulus;
    assign one_m       = (mz == W'(1)) ? '0 : W'(1);

    // node geometry
    always_comb begin
        mid_sum  = {1'b0, r_nl} + {1'b0, r_nr};
        mid      = mid_sum[IW:1];
        nl_c     = CW'(r_nl);
        nr_c     = CW'(r_nr);
        out_rng  = (nr_c < r_lo) || (nl_c > r_hi);
        covered  = (r_lo <= nl_c) && (nr_c <= r_hi);
        node_len = r_nr - r_nl + IW'(1);
        left     = {r_node[AW-2:0], 1'b0};
        right    = {r_node[AW-2:0], 1'b1};
        sp_m1    = r_sp - SPW'(1);
    end

    // range cut on entry
    always_comb begin
        al_c   = CW'(r_alen);
        len_c  = al_c;
        if (al_c == '0) begin
            len_c = CW'(1);
        end else if (al_c > CW'(MAX_ELEMENTS)) begin
            len_c = CW'(MAX_ELEMENTS);
        end
        lo_c   = (i_item.range_low == '0) ? CW'(1) : CW'(i_item.range_low);
        hi_raw = CW'(i_item.range_high);
        hi_c   = (hi_raw > len_c) ? len_c : hi_raw;
        empty  = lo_c > hi_c;
    end

    // shared unit operands
    always_comb begin
        o_mm_a = i_mem_sum;
        o_mm_b = one_m;
        case (r_state)
            rasm_pkg::ST_VRED: o_mm_a = r_val;
            rasm_pkg::ST_AP_T,
            rasm_pkg::ST_PU_T: o_mm_a = i_mem_tag;
            rasm_pkg::ST_AP_P: begin
                o_mm_a = W'(r_ap_len);
                o_mm_b = r_ap_val;
            end
            default: o_mm_a = i_mem_sum;
        endcase
    end

    assign o_mm_m = mz;

    always_comb begin
        n_state     = r_state;
        n_ap_ret    = r_ap_ret;
        n_op        = r_op;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_val       = r_val;
        n_acc       = r_acc;
        n_t         = r_t;
        n_s         = r_s;
        n_p         = r_p;
        n_push      = r_push;
        n_issued    = r_issued;
        n_clr       = r_clr;
        n_out_valid = r_out_valid && !o_result.ready;
        n_out_sum   = r_out_sum;
        n_node      = r_node;
        n_nl        = r_nl;
        n_nr        = r_nr;
        n_ph        = r_ph;
        n_sp        = r_sp;
        n_stk_node  = r_stk_node;
        n_stk_nl    = r_stk_nl;
        n_stk_nr    = r_stk_nr;
        n_stk_ph    = r_stk_ph;
        n_ap_node   = r_ap_node;
        n_ap_len    = r_ap_len;
        n_ap_val    = r_ap_val;
        o_mem_ctl   = '0;
        o_mem_addr  = r_node;
        o_mem_sum   = '0;
        o_mem_tag   = '0;
        o_mm_start  = 1'b0;
        i_item.ready = 1'b0;
        do_pop      = 1'b0;
        do_desc     = 1'b0;
        mm_step     = 1'b0;

        // compute states: start once, then wait for done
        case (r_state)
            rasm_pkg::ST_VRED, rasm_pkg::ST_AP_T, rasm_pkg::ST_AP_S, rasm_pkg::ST_AP_P,
            rasm_pkg::ST_PU_T, rasm_pkg::ST_SUM_L, rasm_pkg::ST_SUM_R,
            rasm_pkg::ST_Q_S: begin
                if (!r_issued) begin
                    o_mm_start = 1'b1;
                    n_issued   = 1'b1;
                end else if (i_mm_done) begin
                    n_issued = 1'b0;
                    mm_step  = 1'b1;
                end
            end
            default: ;
        endcase

        case (r_state)
            rasm_pkg::ST_CLEAR: begin
                o_mem_addr    = r_clr;
                o_mem_ctl.wr_sum = 1'b1;
                o_mem_ctl.wr_tag = 1'b1;
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(NODES - 1)) begin
                    n_state = rasm_pkg::ST_IDLE;
                end
            end
            rasm_pkg::ST_IDLE: begin
                i_item.ready = 1'b1;
                if (i_item.valid) begin
                    n_op   = i_item.opcode;
                    n_lo   = lo_c;
                    n_hi   = hi_c;
                    n_val  = i_item.add_value;
                    n_acc  = '0;
                    n_node = AW'(1);
                    n_nl   = IW'(1);
                    n_nr   = IW'(MAX_ELEMENTS);
                    n_ph   = rasm_pkg::PH_ENTER;
                    n_sp   = '0;
                    if (empty) begin
                        n_state = (i_item.opcode == rasm_pkg::OP_ADD) ?
                                  rasm_pkg::ST_IDLE : rasm_pkg::ST_RESULT;
                    end else begin
                        n_state = (i_item.opcode == rasm_pkg::OP_ADD) ?
                                  rasm_pkg::ST_VRED : rasm_pkg::ST_VISIT;
                    end
                end
            end
            rasm_pkg::ST_VRED: begin
                if (mm_step) begin
                    n_val   = i_mm_res;
                    n_state = rasm_pkg::ST_VISIT;
                end
            end
            rasm_pkg::ST_VISIT: begin
                case (r_ph)
                    rasm_pkg::PH_ENTER: begin
                        if (out_rng) begin
                            do_pop = 1'b1;
                        end else if (covered) begin
                            if (r_op == rasm_pkg::OP_ADD) begin
                                n_ap_node = r_node;
                                n_ap_len  = node_len;
                                n_ap_val  = r_val;
                                n_ap_ret  = rasm_pkg::AR_POP;
                                n_state   = rasm_pkg::ST_AP_RD;
                            end else begin
                                n_state = rasm_pkg::ST_Q_RD;
                            end
                        end else begin
                            n_state = rasm_pkg::ST_PU_RD;
                        end
                    end
                    rasm_pkg::PH_LEFT_DONE: begin
                        n_stk_node[r_sp[SIW-1:0]] = r_node;
                        n_stk_nl[r_sp[SIW-1:0]]   = r_nl;
                        n_stk_nr[r_sp[SIW-1:0]]   = r_nr;
                        n_stk_ph[r_sp[SIW-1:0]]   = rasm_pkg::PH_RIGHT_DONE;
                        n_sp   = r_sp + SPW'(1);
                        n_node = right;
                        n_nl   = mid + IW'(1);
                        n_ph   = rasm_pkg::PH_ENTER;
                    end
                    default: begin
                        if (r_op == rasm_pkg::OP_ADD) begin
                            n_state = rasm_pkg::ST_SUM_RDL;
                        end else begin
                            do_pop = 1'b1;
                        end
                    end
                endcase
            end
            rasm_pkg::ST_AP_RD: begin
                o_mem_addr      = r_ap_node;
                o_mem_ctl.rd_en = 1'b1;
                n_state         = rasm_pkg::ST_AP_T;
            end
            rasm_pkg::ST_AP_T: begin
                if (mm_step) begin
                    n_t     = i_mm_res;
                    n_state = rasm_pkg::ST_AP_S;
                end
            end
            rasm_pkg::ST_AP_S: begin
                if (mm_step) begin
                    n_s     = i_mm_res;
                    n_state = rasm_pkg::ST_AP_P;
                end
            end
            rasm_pkg::ST_AP_P: begin
                if (mm_step) begin
                    n_p     = i_mm_res;
                    n_state = rasm_pkg::ST_AP_WR;
                end
            end
            rasm_pkg::ST_AP_WR: begin
                o_mem_addr       = r_ap_node;
                o_mem_ctl.wr_sum = 1'b1;
                o_mem_ctl.wr_tag = 1'b1;
                o_mem_tag        = rasm_pkg::add_mod(r_t, r_ap_val, mz);
                o_mem_sum        = rasm_pkg::add_mod(r_s, r_p, mz);
                case (r_ap_ret)
                    rasm_pkg::AR_RIGHT: begin
                        n_ap_node = right;
                        n_ap_len  = r_nr - mid;
                        n_ap_ret  = rasm_pkg::AR_DESCEND;
                        n_state   = rasm_pkg::ST_AP_RD;
                    end
                    rasm_pkg::AR_DESCEND: do_desc = 1'b1;
                    default:              do_pop  = 1'b1;
                endcase
            end
            rasm_pkg::ST_PU_RD: begin
                o_mem_ctl.rd_en = 1'b1;
                n_state         = rasm_pkg::ST_PU_T;
            end
            rasm_pkg::ST_PU_T: begin
                if (mm_step) begin
                    n_push  = i_mm_res;
                    n_state = rasm_pkg::ST_PU_WR;
                end
            end
            rasm_pkg::ST_PU_WR: begin
                o_mem_ctl.wr_tag = 1'b1;
                if (r_push == '0) begin
                    do_desc = 1'b1;
                end else begin
                    n_ap_node = left;
                    n_ap_len  = mid - r_nl + IW'(1);
                    n_ap_val  = r_push;
                    n_ap_ret  = rasm_pkg::AR_RIGHT;
                    n_state   = rasm_pkg::ST_AP_RD;
                end
            end
            rasm_pkg::ST_SUM_RDL: begin
                o_mem_addr      = left;
                o_mem_ctl.rd_en = 1'b1;
                n_state         = rasm_pkg::ST_SUM_L;
            end
            rasm_pkg::ST_SUM_L: begin
                if (mm_step) begin
                    n_s     = i_mm_res;
                    n_state = rasm_pkg::ST_SUM_RDR;
                end
            end
            rasm_pkg::ST_SUM_RDR: begin
                o_mem_addr      = right;
                o_mem_ctl.rd_en = 1'b1;
                n_state         = rasm_pkg::ST_SUM_R;
            end
            rasm_pkg::ST_SUM_R: begin
                if (mm_step) begin
                    n_p     = i_mm_res;
                    n_state = rasm_pkg::ST_SUM_WR;
                end
            end
            rasm_pkg::ST_SUM_WR: begin
                o_mem_ctl.wr_sum = 1'b1;
                o_mem_sum        = rasm_pkg::add_mod(r_s, r_p, mz);
                do_pop           = 1'b1;
            end
            rasm_pkg::ST_Q_RD: begin
                o_mem_ctl.rd_en = 1'b1;
                n_state         = rasm_pkg::ST_Q_S;
            end
            rasm_pkg::ST_Q_S: begin
                if (mm_step) begin
                    n_acc  = rasm_pkg::add_mod(r_acc, i_mm_res, mz);
                    do_pop = 1'b1;
                end
            end
            rasm_pkg::ST_RESULT: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid = 1'b1;
                    n_out_sum   = r_acc;
                    n_state     = rasm_pkg::ST_IDLE;
                end
            end
            default: n_state = rasm_pkg::ST_IDLE;
        endcase

        if (do_desc) begin
            n_stk_node[r_sp[SIW-1:0]] = r_node;
            n_stk_nl[r_sp[SIW-1:0]]   = r_nl;
            n_stk_nr[r_sp[SIW-1:0]]   = r_nr;
            n_stk_ph[r_sp[SIW-1:0]]   = rasm_pkg::PH_LEFT_DONE;
            n_sp    = r_sp + SPW'(1);
            n_node  = left;
            n_nr    = mid;
            n_ph    = rasm_pkg::PH_ENTER;
            n_state = rasm_pkg::ST_VISIT;
        end

        if (do_pop) begin
            if (r_sp == '0) begin
                n_state = (r_op == rasm_pkg::OP_ADD) ? rasm_pkg::ST_IDLE : rasm_pkg::ST_RESULT;
            end else begin
                n_node  = r_stk_node[sp_m1[SIW-1:0]];
                n_nl    = r_stk_nl[sp_m1[SIW-1:0]];
                n_nr    = r_stk_nr[sp_m1[SIW-1:0]];
                n_ph    = r_stk_ph[sp_m1[SIW-1:0]];
                n_sp    = sp_m1;
                n_state = rasm_pkg::ST_VISIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rasm_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
            r_sp        <= '0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_issued    <= n_issued;
            r_out_valid <= n_out_valid;
            r_sp        <= n_sp;
        end
        r_ap_ret   <= n_ap_ret;
        r_op       <= n_op;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_val      <= n_val;
        r_acc      <= n_acc;
        r_t        <= n_t;
        r_s        <= n_s;
        r_p        <= n_p;
        r_push     <= n_push;
        r_out_sum  <= n_out_sum;
        r_node     <= n_node;
        r_nl       <= n_nl;
        r_nr       <= n_nr;
        r_ph       <= n_ph;
        r_stk_node <= n_stk_node;
        r_stk_nl   <= n_stk_nl;
        r_stk_nr   <= n_stk_nr;
        r_stk_ph   <= n_stk_ph;
        r_ap_node  <= n_ap_node;
        r_ap_len   <= n_ap_len;
        r_ap_val   <= n_ap_val;
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.range_sum = r_out_sum;

    `RASM_ASSERT_IMP(a_sp_bound, i_clk, i_rst_n, 1'b1, r_sp <= SPW'(D))
    `RASM_ASSERT_IMP(a_idle_sp, i_clk, i_rst_n, r_state == rasm_pkg::ST_IDLE, r_sp == '0)
    `RASM_ASSERT_NXT(a_mm_start, i_clk, i_rst_n, o_mm_start, !i_mm_done)
    `RASM_ASSERT_IMP(a_acc_range, i_clk, i_rst_n, r_state == rasm_pkg::ST_RESULT, r_acc < mz)

endmodule

`default_nettype wire

// File: hw/rtl/range_add_range_sum_mod_unit.sv
// Range add / range sum modulo M over a lazy segment tree, one shared modular multiplier.
// A tag apply reduces tag and sum and forms length * value; a lazy push reduces the tag and,
// if nonzero, applies it to both children; a child-sum update reduces both child sums; a covered
// query node or value reduce is one pass. A range op visits up to about 4*log2(MAX_ELEMENTS)
// nodes; empty ranges skip the walk. Throughput: one word at a time; the next word is taken
// once the walk ends. Reset: synchronous active low; a clearing pass zeroes the tree, ready low.
`default_nettype none

module range_add_range_sum_mod_unit #(
    parameter int MAX_ELEMENTS = rasm_pkg::MAX_ELEMENTS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rasm_in_if.sink    i_item,
    rasm_out_if.source o_result,
    rasm_cfg_if.sink   i_cfg
);

    localparam int AW = $clog2(4 * MAX_ELEMENTS);

    rasm_pkg::t_mem_ctl          mem_ctl;
    logic [AW-1:0]               mem_addr;
    logic [rasm_pkg::DATA_W-1:0] mem_wsum, mem_wtag, mem_rsum, mem_rtag;
    logic                        mm_start, mm_done;
    logic [rasm_pkg::DATA_W-1:0] mm_a, mm_b, mm_m, mm_res;

    rasm_ctrl #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .o_result   (o_result),
        .i_cfg      (i_cfg),
        .o_mem_ctl  (mem_ctl),
        .o_mem_addr (mem_addr),
        .o_mem_sum  (mem_wsum),
        .o_mem_tag  (mem_wtag),
        .i_mem_sum  (mem_rsum),
        .i_mem_tag  (mem_rtag),
        .o_mm_start (mm_start),
        .o_mm_a     (mm_a),
        .o_mm_b     (mm_b),
        .o_mm_m     (mm_m),
        .i_mm_done  (mm_done),
        .i_mm_res   (mm_res)
    );

    rasm_mem #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_mem (
        .i_clk  (i_clk),
        .i_ctl  (mem_ctl),
        .i_addr (mem_addr),
        .i_sum  (mem_wsum),
        .i_tag  (mem_wtag),
        .o_sum  (mem_rsum),
        .o_tag  (mem_rtag)
    );

    rasm_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mm_start),
        .i_a     (mm_a),
        .i_b     (mm_b),
        .i_m     (mm_m),
        .o_done  (mm_done),
        .o_res   (mm_res)
    );

endmodule

`default_nettype wire
